// ----- hw/rtl/leb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// leb_pkg
// shared types, command, key and status codes of the line edit buffer
// ----------------------------------------------------------------------------
package leb_pkg;

  localparam int LINE_MAX = 70;
  localparam int CNT_W    = $clog2(LINE_MAX + 1);
  localparam int ADDR_W   = $clog2(LINE_MAX);

  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_PRELOAD = 2'd1;
  localparam logic [1:0] CMD_KEY     = 2'd2;
  localparam logic [1:0] CMD_READ    = 2'd3;

  localparam logic [7:0] KEY_NUL   = 8'd0;
  localparam logic [7:0] KEY_ABORT = 8'd3;
  localparam logic [7:0] KEY_BACK  = 8'd8;
  localparam logic [7:0] KEY_CR    = 8'd13;
  localparam logic [7:0] KEY_ESC   = 8'h1b;
  localparam logic [7:0] KEY_RIGHT = 8'd28;
  localparam logic [7:0] KEY_LEFT  = 8'd29;
  localparam logic [7:0] KEY_HOME  = 8'd200;
  localparam logic [7:0] KEY_END   = 8'd201;
  localparam logic [7:0] KEY_TRUNC = 8'd205;
  localparam logic [7:0] KEY_INS   = 8'd206;
  localparam logic [7:0] KEY_DEL   = 8'd207;

  localparam logic [2:0] ST_EDIT       = 3'd0;
  localparam logic [2:0] ST_ACCEPT     = 3'd1;
  localparam logic [2:0] ST_ABORT      = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_NO_SESSION = 3'd4;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_code;
    logic [6:0] position;
  } leb_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] cursor;
    logic [6:0] length;
    logic       insert_mode;
    logic [7:0] read_char;
  } leb_rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } leb_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } leb_rd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/line_edit_buffer_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// line_edit_buffer_core
// keystroke line editor: line held in a one-port-read, one-port-write store
// ----------------------------------------------------------------------------
// sequence: dispatch, then done for most items; insert, backspace and delete
//   pass shift and tail states between them, moving n characters (at most 69)
//   one per cycle through the store's single read and write port
// throughput: a new item is accepted in the done cycle of the previous one
// the receiver cannot stall; each result is shown for one cycle with done
// reset: synchronous; empty line, cursor 0, overwrite mode, no session
// ----------------------------------------------------------------------------
module line_edit_buffer_core import leb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire leb_req_t request,
  output logic          busy,
  output logic          done,
  output leb_rsp_t      response
);

  leb_wr_t    mem_wr;
  leb_rd_t    mem_rd;
  logic [7:0] mem_rdata;

  leb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .done      (done),
    .response  (response),
    .mem_wr    (mem_wr),
    .mem_rd    (mem_rd),
    .mem_rdata (mem_rdata)
  );

  leb_line_ram u_ram (
    .clk   (clk),
    .wr    (mem_wr),
    .rd    (mem_rd),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/leb_line_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// leb_line_ram
// character store of the line, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module leb_line_ram import leb_pkg::*; (
  input  wire logic       clk,
  input  wire leb_wr_t    wr,
  input  wire leb_rd_t    rd,
  output logic [7:0]      rdata
);

  logic [7:0] mem [LINE_MAX];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/leb_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// leb_ctrl
// command decode, cursor and length registers, shift sequencer over the store
// ----------------------------------------------------------------------------
module leb_ctrl import leb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire leb_req_t   request,
  output logic            busy,
  output logic            done,
  output leb_rsp_t        response,
  output leb_wr_t         mem_wr,
  output leb_rd_t         mem_rd,
  input  wire logic [7:0] mem_rdata
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SHIFT    = 3'd2;
  localparam logic [2:0] S_TAIL     = 3'd3;
  localparam logic [2:0] S_DONE     = 3'd4;

  logic [2:0]        state, state_next;
  leb_req_t          req, req_next;
  logic [CNT_W-1:0]  cursor, cursor_next;
  logic [CNT_W-1:0]  length, length_next;
  logic              insert_flag, insert_flag_next;
  logic              first_key, first_key_next;
  logic              session, session_next;
  logic [2:0]        status, status_next;
  logic              rd_valid, rd_valid_next;
  logic              wr_char, wr_char_next;
  logic [ADDR_W-1:0] char_addr, char_addr_next;
  logic              wr_pend, wr_pend_next;
  logic [ADDR_W-1:0] wr_addr, wr_addr_next;
  logic [ADDR_W-1:0] rd_ptr, rd_ptr_next;
  logic [ADDR_W-1:0] rd_last, rd_last_next;
  logic              shift_right, shift_right_next;
  logic              read_hit;
  logic              line_full;

  assign read_hit  = (req.cmd == CMD_READ) && (req.position < length);
  assign line_full = (length == CNT_W'(LINE_MAX));

  always_comb begin
    state_next       = state;
    req_next         = req;
    cursor_next      = cursor;
    length_next      = length;
    insert_flag_next = insert_flag;
    first_key_next   = first_key;
    session_next     = session;
    status_next      = status;
    rd_valid_next    = rd_valid;
    wr_char_next     = wr_char;
    char_addr_next   = char_addr;
    wr_pend_next     = 1'b0;
    wr_addr_next     = wr_addr;
    rd_ptr_next      = rd_ptr;
    rd_last_next     = rd_last;
    shift_right_next = shift_right;

    unique case (state)
      S_IDLE, S_DONE: begin
        if (state == S_DONE) begin
          wr_char_next = 1'b0;
        end
        if (start) begin
          req_next   = request;
          state_next = S_DISPATCH;
        end else begin
          state_next = S_IDLE;
        end
      end

      S_DISPATCH: begin
        status_next   = ST_EDIT;
        rd_valid_next = 1'b0;
        wr_char_next  = 1'b0;
        state_next    = S_DONE;
        unique case (req.cmd)
          CMD_START: begin
            cursor_next      = '0;
            length_next      = '0;
            insert_flag_next = 1'b0;
            first_key_next   = 1'b1;
            session_next     = 1'b1;
          end
          CMD_PRELOAD: begin
            if (!session) begin
              status_next = ST_NO_SESSION;
            end else if (req.char_code != KEY_NUL) begin
              if (line_full) begin
                status_next = ST_FULL;
              end else begin
                wr_char_next   = 1'b1;
                char_addr_next = length[ADDR_W-1:0];
                length_next    = length + CNT_W'(1);
              end
            end
          end
          CMD_KEY: begin
            if (!session) begin
              status_next = ST_NO_SESSION;
            end else begin
              first_key_next = 1'b0;
              unique case (req.char_code) inside
                KEY_ABORT: begin
                  first_key_next = first_key;
                  cursor_next    = '0;
                  length_next    = '0;
                  session_next   = 1'b0;
                  status_next    = ST_ABORT;
                end
                KEY_CR, KEY_ESC: begin
                  first_key_next = first_key;
                  session_next   = 1'b0;
                  status_next    = ST_ACCEPT;
                end
                KEY_LEFT: begin
                  if (cursor != '0) begin
                    cursor_next = cursor - CNT_W'(1);
                  end
                end
                KEY_RIGHT: begin
                  if (cursor < length) begin
                    cursor_next = cursor + CNT_W'(1);
                  end
                end
                KEY_BACK: begin
                  if (cursor != '0) begin
                    cursor_next = cursor - CNT_W'(1);
                    length_next = length - CNT_W'(1);
                    if (cursor < length) begin
                      rd_ptr_next      = cursor[ADDR_W-1:0];
                      rd_last_next     = ADDR_W'(length - CNT_W'(1));
                      shift_right_next = 1'b0;
                      state_next       = S_SHIFT;
                    end
                  end
                end
                KEY_DEL: begin
                  if (cursor < length) begin
                    length_next = length - CNT_W'(1);
                    if ((cursor + CNT_W'(1)) < length) begin
                      rd_ptr_next      = ADDR_W'(cursor + CNT_W'(1));
                      rd_last_next     = ADDR_W'(length - CNT_W'(1));
                      shift_right_next = 1'b0;
                      state_next       = S_SHIFT;
                    end
                  end
                end
                KEY_INS: begin
                  insert_flag_next = ~insert_flag;
                end
                KEY_HOME: begin
                  cursor_next = '0;
                end
                KEY_END: begin
                  cursor_next = length;
                end
                KEY_TRUNC: begin
                  length_next = cursor;
                end
                KEY_NUL: begin
                  status_next = ST_EDIT;
                end
                default: begin
                  if (line_full) begin
                    status_next = ST_FULL;
                  end else begin
                    wr_char_next   = 1'b1;
                    char_addr_next = cursor[ADDR_W-1:0];
                    cursor_next    = cursor + CNT_W'(1);
                    if (insert_flag) begin
                      length_next = length + CNT_W'(1);
                      if (cursor < length) begin
                        rd_ptr_next      = ADDR_W'(length - CNT_W'(1));
                        rd_last_next     = cursor[ADDR_W-1:0];
                        shift_right_next = 1'b1;
                        state_next       = S_SHIFT;
                      end
                    end else if (first_key || (cursor == length)) begin
                      length_next = cursor + CNT_W'(1);
                    end
                  end
                end
              endcase
            end
          end
          CMD_READ: begin
            status_next   = session ? ST_EDIT : ST_NO_SESSION;
            rd_valid_next = read_hit;
          end
          default: begin
            status_next = ST_EDIT;
          end
        endcase
      end

      S_SHIFT: begin
        wr_pend_next = 1'b1;
        if (shift_right) begin
          rd_ptr_next  = rd_ptr - ADDR_W'(1);
          wr_addr_next = rd_ptr + ADDR_W'(1);
        end else begin
          rd_ptr_next  = rd_ptr + ADDR_W'(1);
          wr_addr_next = rd_ptr - ADDR_W'(1);
        end
        if (rd_ptr == rd_last) begin
          state_next = S_TAIL;
        end
      end

      S_TAIL: begin
        state_next = S_DONE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cursor      <= '0;
      length      <= '0;
      insert_flag <= 1'b0;
      first_key   <= 1'b1;
      session     <= 1'b0;
      status      <= ST_EDIT;
      rd_valid    <= 1'b0;
      wr_char     <= 1'b0;
      wr_pend     <= 1'b0;
    end else begin
      state       <= state_next;
      cursor      <= cursor_next;
      length      <= length_next;
      insert_flag <= insert_flag_next;
      first_key   <= first_key_next;
      session     <= session_next;
      status      <= status_next;
      rd_valid    <= rd_valid_next;
      wr_char     <= wr_char_next;
      wr_pend     <= wr_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    req         <= req_next;
    char_addr   <= char_addr_next;
    wr_addr     <= wr_addr_next;
    rd_ptr      <= rd_ptr_next;
    rd_last     <= rd_last_next;
    shift_right <= shift_right_next;
  end

  // store ports
  always_comb begin
    mem_wr.we   = wr_pend || ((state == S_DONE) && wr_char);
    mem_wr.addr = wr_pend ? wr_addr : char_addr;
    mem_wr.data = wr_pend ? mem_rdata : req.char_code;
    mem_rd.re   = (state == S_SHIFT) || ((state == S_DISPATCH) && read_hit);
    mem_rd.addr = (state == S_SHIFT) ? rd_ptr : req.position[ADDR_W-1:0];
  end

  assign busy = (state != S_IDLE) && (state != S_DONE);
  assign done = (state == S_DONE);

  always_comb begin
    response.status      = status;
    response.cursor      = cursor;
    response.length      = length;
    response.insert_mode = insert_flag;
    response.read_char   = rd_valid ? mem_rdata : 8'd0;
  end

`ifndef SYNTHESIS
  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst)
    cursor <= length)
    else $error("cursor beyond end of line");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    length <= CNT_W'(LINE_MAX))
    else $error("line length beyond maximum");

  a_shift_write_window: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> (state == S_SHIFT || state == S_TAIL))
    else $error("shift write outside shift sequence");

  a_char_write_alone: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && wr_char) |-> !wr_pend && !mem_rd.re)
    else $error("character write collides with shift traffic");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");
`endif

endmodule
`default_nettype wire

// ----- sim/line_edit_buffer_core_tb.sv -----
// ----------------------------------------------------------------------------
// line_edit_buffer_core_tb
// self-checking bench for the keystroke line editor: a short scripted run
// over the editing keys and session corner cases, then random editing
// sessions (some filling the line) checked against an in-bench line model
// ----------------------------------------------------------------------------
module line_edit_buffer_core_tb;
  import leb_pkg::*;

  typedef struct packed {
    leb_req_t req;
    logic     typed;
    leb_rsp_t want;
  } script_row_t;

  localparam int SCRIPT_LEN = 33;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{'{CMD_READ,    8'h00,     7'd0},   1'b1, '{ST_NO_SESSION, 7'd0, 7'd0, 1'b0, 8'h00}},
    '{'{CMD_KEY,     8'h61,     7'd5},   1'b1, '{ST_NO_SESSION, 7'd0, 7'd0, 1'b0, 8'h00}},
    '{'{CMD_PRELOAD, 8'h78,     7'd0},   1'b1, '{ST_NO_SESSION, 7'd0, 7'd0, 1'b0, 8'h00}},
    '{'{CMD_START,   8'h00,     7'd0},   1'b1, '{ST_EDIT,       7'd0, 7'd0, 1'b0, 8'h00}},
    '{'{CMD_PRELOAD, 8'h00,     7'd0},   1'b1, '{ST_EDIT,       7'd0, 7'd0, 1'b0, 8'h00}},
    '{'{CMD_PRELOAD, 8'hff,     7'h7f},  1'b1, '{ST_EDIT,       7'd0, 7'd1, 1'b0, 8'h00}},
    '{'{CMD_PRELOAD, 8'h01,     7'd0},   1'b1, '{ST_EDIT,       7'd0, 7'd2, 1'b0, 8'h00}},
    '{'{CMD_KEY,     KEY_RIGHT, 7'd0},   1'b0, '0},
    '{'{CMD_KEY,     8'h41,     7'd0},   1'b0, '0},
    '{'{CMD_KEY,     KEY_LEFT,  7'd0},   1'b0, '0},
    '{'{CMD_KEY,     8'h42,     7'd0},   1'b0, '0},
    '{'{CMD_KEY,     KEY_INS,   7'd0},   1'b0, '0},
    '{'{CMD_KEY,     KEY_HOME,  7'd0},   1'b0, '0},
    '{'{CMD_KEY,     KEY_LEFT,  7'd0},   1'b0, '0},
    '{'{CMD_KEY,     8'hfe,     7'd0},   1'b0, '0},
    '{'{CMD_KEY,     KEY_END,   7'd0},   1'b0, '0},
    '{'{CMD_KEY,     KEY_RIGHT, 7'd0},   1'b0, '0},
    '{'{CMD_KEY,     KEY_DEL,   7'd0},   1'b0, '0},
    '{'{CMD_KEY,     KEY_BACK,  7'd0},   1'b0, '0},
    '{'{CMD_KEY,     KEY_HOME,  7'd0},   1'b0, '0},
    '{'{CMD_KEY,     KEY_DEL,   7'd0},   1'b0, '0},
    '{'{CMD_KEY,     KEY_NUL,   7'd0},   1'b0, '0},
    '{'{CMD_KEY,     8'h3b,     7'd0},   1'b0, '0},
    '{'{CMD_KEY,     KEY_TRUNC, 7'd0},   1'b0, '0},
    '{'{CMD_READ,    8'h00,     7'h7f},  1'b0, '0},
    '{'{CMD_KEY,     KEY_ESC,   7'd0},   1'b0, '0},
    '{'{CMD_READ,    8'hff,     7'd0},   1'b0, '0},
    '{'{CMD_START,   8'h00,     7'd0},   1'b1, '{ST_EDIT,       7'd0, 7'd0, 1'b0, 8'h00}},
    '{'{CMD_KEY,     KEY_CR,    7'd0},   1'b1, '{ST_ACCEPT,     7'd0, 7'd0, 1'b0, 8'h00}},
    '{'{CMD_START,   8'h00,     7'd0},   1'b1, '{ST_EDIT,       7'd0, 7'd0, 1'b0, 8'h00}},
    '{'{CMD_PRELOAD, 8'h7a,     7'd0},   1'b1, '{ST_EDIT,       7'd0, 7'd1, 1'b0, 8'h00}},
    '{'{CMD_KEY,     KEY_ABORT, 7'd0},   1'b1, '{ST_ABORT,      7'd0, 7'd0, 1'b0, 8'h00}},
    '{'{CMD_KEY,     KEY_BACK,  7'd0},   1'b1, '{ST_NO_SESSION, 7'd0, 7'd0, 1'b0, 8'h00}}
  };

  localparam logic [7:0] EDIT_KEYS [9] = '{KEY_LEFT, KEY_RIGHT, KEY_HOME, KEY_END, KEY_BACK,
                                          KEY_DEL, KEY_TRUNC, KEY_INS, KEY_NUL};

  logic     clk;
  logic     rst;
  logic     start;
  leb_req_t request;
  logic     busy;
  logic     done;
  leb_rsp_t response;

  logic [7:0] ed_line [LINE_MAX + 2];
  int         ed_cursor;
  logic       ed_insert;
  logic       ed_first;
  logic       ed_open;

  leb_rsp_t due_rsp [$];
  leb_rsp_t rsp_want;
  int       fail_count;
  int       items_sent;

  line_edit_buffer_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .request  (request),
    .busy     (busy),
    .done     (done),
    .response (response)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void wipe_line();
    for (int i = 0; i < LINE_MAX + 2; i++) ed_line[i] = 8'h00;
  endfunction

  function automatic int line_count();
    int n;
    n = 0;
    while (n < LINE_MAX && ed_line[n] != 8'h00) n++;
    return n;
  endfunction

  function automatic logic [2:0] apply_key(logic [7:0] k);
    int n;
    int i;
    logic [2:0] st;
    n = line_count();
    st = ST_EDIT;
    case (k)
      KEY_ABORT: begin
        wipe_line();
        ed_cursor = 0;
        ed_open = 1'b0;
        return ST_ABORT;
      end
      KEY_LEFT: if (ed_cursor > 0) ed_cursor--;
      KEY_RIGHT: if (ed_cursor < n) ed_cursor++;
      KEY_BACK: begin
        if (ed_cursor > 0) begin
          for (i = ed_cursor - 1; i <= n - 1; i++) ed_line[i] = ed_line[i + 1];
          ed_cursor--;
        end
      end
      KEY_INS: ed_insert = ~ed_insert;
      KEY_DEL: begin
        for (i = ed_cursor; i < n; i++) ed_line[i] = ed_line[i + 1];
      end
      KEY_HOME: ed_cursor = 0;
      KEY_END: ed_cursor = n;
      KEY_TRUNC: ed_line[ed_cursor] = 8'h00;
      KEY_ESC, KEY_CR: begin
        ed_open = 1'b0;
        return ST_ACCEPT;
      end
      KEY_NUL: ;
      default: begin
        if (n >= LINE_MAX) begin
          st = ST_FULL;
        end else begin
          if (ed_insert) begin
            for (i = n; i >= ed_cursor; i--) ed_line[i + 1] = ed_line[i];
          end else begin
            if (ed_first) ed_line[ed_cursor] = 8'h00;
            if (ed_line[ed_cursor] == 8'h00) ed_line[ed_cursor + 1] = 8'h00;
          end
          ed_line[ed_cursor] = k;
          ed_cursor++;
        end
      end
    endcase
    ed_first = 1'b0;
    return st;
  endfunction

  function automatic leb_rsp_t predict_edit(leb_req_t r);
    leb_rsp_t o;
    int n;
    o = '0;
    case (r.cmd)
      CMD_START: begin
        wipe_line();
        ed_cursor = 0;
        ed_insert = 1'b0;
        ed_first = 1'b1;
        ed_open = 1'b1;
      end
      CMD_PRELOAD: begin
        if (!ed_open) begin
          o.status = ST_NO_SESSION;
        end else if (r.char_code != 8'h00) begin
          n = line_count();
          if (n >= LINE_MAX) begin
            o.status = ST_FULL;
          end else begin
            ed_line[n] = r.char_code;
            ed_line[n + 1] = 8'h00;
          end
        end
      end
      CMD_KEY: begin
        if (!ed_open) o.status = ST_NO_SESSION;
        else o.status = apply_key(r.char_code);
      end
      default: begin
        n = line_count();
        if (int'(r.position) < n) o.read_char = ed_line[r.position];
        o.status = ed_open ? ST_EDIT : ST_NO_SESSION;
      end
    endcase
    o.cursor = 7'(ed_cursor);
    o.length = 7'(line_count());
    o.insert_mode = ed_insert;
    return o;
  endfunction

  function automatic leb_req_t req_of(logic [1:0] c, logic [7:0] ch, logic [6:0] p);
    leb_req_t r;
    r.cmd = c;
    r.char_code = ch;
    r.position = p;
    return r;
  endfunction

  function automatic logic [6:0] read_pos();
    if ($urandom_range(0, 4) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(0, 71));
  endfunction

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic put_item(input leb_req_t r, input logic typed = 1'b0,
                          input leb_rsp_t want = '0);
    leb_rsp_t got;
    while (!(items_sent >= 200 && items_sent < 330) && $urandom_range(0, 99) < 11) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    items_sent++;
    got = predict_edit(r);
    due_rsp.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (due_rsp.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic flag_field(input string name, input logic [7:0] want_v,
                            input logic [7:0] got_v);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (due_rsp.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, response);
        fail_count++;
      end else begin
        rsp_want = due_rsp.pop_front();
        if (response.status !== rsp_want.status)
          flag_field("status", 8'(rsp_want.status), 8'(response.status));
        if (response.cursor !== rsp_want.cursor)
          flag_field("cursor", 8'(rsp_want.cursor), 8'(response.cursor));
        if (response.length !== rsp_want.length)
          flag_field("length", 8'(rsp_want.length), 8'(response.length));
        if (response.insert_mode !== rsp_want.insert_mode)
          flag_field("insert_mode", 8'(rsp_want.insert_mode), 8'(response.insert_mode));
        if (response.read_char !== rsp_want.read_char)
          flag_field("read_char", rsp_want.read_char, response.read_char);
      end
    end
  end

  initial begin
    int kind;
    int pick;
    int sessions;
    int guard;
    logic [7:0] ch;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    fail_count = 0;
    items_sent = 0;
    sessions = 0;
    wipe_line();
    ed_cursor = 0;
    ed_insert = 1'b0;
    ed_first = 1'b1;
    ed_open = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_LEN; i++) put_item(SCRIPT[i].req, SCRIPT[i].typed, SCRIPT[i].want);
    drain_results();

    while (items_sent < 550) begin
      // kind 0 skips the session start, kind 1 fills the line up
      kind = (sessions == 0) ? 1 : $urandom_range(0, 7);
      if (kind != 0) put_item(req_of(CMD_START, 8'($urandom), 7'($urandom)));
      repeat ((kind == 1) ? $urandom_range(62, 74) : $urandom_range(0, 10)) begin
        ch = ($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        put_item(req_of(CMD_PRELOAD, ch, 7'($urandom)));
      end
      repeat ($urandom_range(4, 30)) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          do ch = 8'($urandom_range(0, 255));
          while (ch == KEY_ABORT || ch == KEY_CR || ch == KEY_ESC);
          put_item(req_of(CMD_KEY, ch, 7'($urandom)));
        end else if (pick < 75) begin
          put_item(req_of(CMD_KEY, EDIT_KEYS[$urandom_range(0, 8)], 7'($urandom)));
        end else if (pick < 87) begin
          put_item(req_of(CMD_READ, 8'($urandom), read_pos()));
        end else if (pick < 93) begin
          put_item(req_of(CMD_PRELOAD, 8'($urandom), 7'($urandom)));
        end else if (pick < 95) begin
          put_item(req_of(CMD_START, 8'($urandom), 7'($urandom)));
        end else begin
          put_item(req_of(CMD_KEY, 8'($urandom), 7'($urandom)));
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 25) put_item(req_of(CMD_KEY, KEY_ESC, 7'($urandom)));
      else if (pick < 45) put_item(req_of(CMD_KEY, KEY_CR, 7'($urandom)));
      else if (pick < 70) put_item(req_of(CMD_KEY, KEY_ABORT, 7'($urandom)));
      repeat ($urandom_range(0, 3)) put_item(req_of(CMD_READ, 8'($urandom), read_pos()));
      if (sessions == 0 || $urandom_range(0, 4) == 0) drain_results();
      sessions++;
    end

    start <= 1'b0;
    guard = 0;
    while (due_rsp.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
    if (fail_count == 0 && due_rsp.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (due_rsp.size() != 0) $display("%0t: %0d results never arrived", $time, due_rsp.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/leb_pkg.sv
hw/rtl/leb_line_ram.sv
hw/rtl/leb_ctrl.sv
hw/rtl/line_edit_buffer_core.sv
sim/line_edit_buffer_core_tb.sv
